// ===== rtl/core/pps_pkg.sv =====
// Package for the pretoken piece splitter: item types, byte codes, piece modes.
// Used by every module of the block and by its checker; depends on nothing.
`default_nettype none

package pps_pkg;

  // Input item: one raw text byte and the text-end mark
  typedef struct packed {
    logic [7:0] byte_in;
    logic       text_end;
  } pps_in_t;

  // Result item: one decided byte and its piece flags
  typedef struct packed {
    logic [7:0] byte_out;
    logic       piece_end;
    logic       run_last;
  } pps_out_t;

  // Results produced by one input item, oldest in slot 0
  localparam int unsigned MAX_RES = 3;

  typedef struct packed {
    logic [1:0]                 cnt;
    pps_out_t [MAX_RES-1:0]     res;
  } pps_grp_t;

  // Piece role of the oldest undecided byte
  localparam logic [2:0] MODE_START  = 3'd0;
  localparam logic [2:0] MODE_LETTER = 3'd1;
  localparam logic [2:0] MODE_PUNCT  = 3'd2;
  localparam logic [2:0] MODE_BREAK  = 3'd3;
  localparam logic [2:0] MODE_SPACE  = 3'd4;
  localparam logic [2:0] MODE_TAIL2  = 3'd5;
  localparam logic [2:0] MODE_TAIL1  = 3'd6;

  // Undecided bytes held between items, oldest in b0
  typedef struct packed {
    logic [1:0] held_cnt;
    logic [2:0] mode;
    logic [7:0] b0;
    logic [7:0] b1;
  } pps_hold_t;

  // Byte codes
  localparam logic [7:0] CH_APOS  = 8'h27;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UZ    = 8'h5A;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LZ    = 8'h7A;
  localparam logic [7:0] CH_HIGH  = 8'h80;
  localparam logic [7:0] CH_S     = 8'h73;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_M     = 8'h6D;
  localparam logic [7:0] CH_D     = 8'h64;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_V     = 8'h76;
  localparam logic [7:0] CH_L     = 8'h6C;
  localparam logic [7:0] CH_E     = 8'h65;
  localparam logic [7:0] CASE_GAP = 8'h20;

  // Result queue depth (power of two, at least 4)
  localparam int unsigned OUTQ_DEPTH = 8;

endpackage

`default_nettype wire

// ===== rtl/core/pps_step.sv =====
// Piece decision logic: appends one byte to the held bytes and decides up to
// three of them in one combinational pass. Depends on pps_pkg.
`default_nettype none

module pps_step (
  input  pps_pkg::pps_hold_t hold,
  input  pps_pkg::pps_in_t   item,
  output pps_pkg::pps_grp_t  grp,
  output pps_pkg::pps_hold_t hold_nxt
);

  typedef struct packed {
    logic       ok;
    logic       pend;
    logic [2:0] next;
  } pps_dec_t;

  function automatic logic is_letter(input logic [7:0] b);
    return (b >= pps_pkg::CH_UA && b <= pps_pkg::CH_UZ) ||
           (b >= pps_pkg::CH_LA && b <= pps_pkg::CH_LZ) || (b >= pps_pkg::CH_HIGH);
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return b >= pps_pkg::CH_0 && b <= pps_pkg::CH_9;
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    return b == pps_pkg::CH_SPACE || (b >= pps_pkg::CH_TAB && b <= pps_pkg::CH_CR);
  endfunction

  function automatic logic is_break(input logic [7:0] b);
    return b == pps_pkg::CH_CR || b == pps_pkg::CH_LF;
  endfunction

  function automatic logic is_punct(input logic [7:0] b);
    return !is_letter(b) && !is_digit(b) && !is_space(b);
  endfunction

  function automatic logic [7:0] lower(input logic [7:0] b);
    return (b >= pps_pkg::CH_UA && b <= pps_pkg::CH_UZ) ? b + pps_pkg::CASE_GAP : b;
  endfunction

  // Decide the oldest byte c given up to two following bytes
  function automatic pps_dec_t decide(input logic [7:0] c, input logic [7:0] n1,
                                      input logic [7:0] n2, input logic [1:0] cnt,
                                      input logic fin, input logic [2:0] mode);
    pps_dec_t   res;
    logic [2:0] m;
    logic [2:0] nx;
    logic       done;
    logic       wait_n2;
    logic       n1h, n1u, n2h, n2u;
    logic [7:0] l1;
    res     = '0;
    m       = mode;
    nx      = pps_pkg::MODE_START;
    done    = 1'b0;
    wait_n2 = 1'b0;
    n1h     = cnt > 2'd1;
    n1u     = !n1h && !fin;
    n2h     = cnt > 2'd2;
    n2u     = !n2h && !fin;
    l1      = lower(n1);
    // Piece start: contractions, prefixed letter runs, space-led punctuation, digits
    if (mode == pps_pkg::MODE_START || mode > pps_pkg::MODE_TAIL1) begin
      if (c == pps_pkg::CH_APOS) begin
        if (n1u) begin
          done = 1'b1;
        end else if (n1h) begin
          if (l1 == pps_pkg::CH_S || l1 == pps_pkg::CH_T ||
              l1 == pps_pkg::CH_M || l1 == pps_pkg::CH_D) begin
            res.ok   = 1'b1;
            res.next = pps_pkg::MODE_TAIL1;
            done     = 1'b1;
          end else if (l1 == pps_pkg::CH_R || l1 == pps_pkg::CH_V || l1 == pps_pkg::CH_L) begin
            if (n2u) begin
              done = 1'b1;
            end else if (n2h && lower(n2) ==
                         ((l1 == pps_pkg::CH_L) ? pps_pkg::CH_L : pps_pkg::CH_E)) begin
              res.ok   = 1'b1;
              res.next = pps_pkg::MODE_TAIL2;
              done     = 1'b1;
            end
          end
        end
      end
      if (!done && (is_punct(c) || c == pps_pkg::CH_SPACE)) begin
        if (n1u) begin
          done = 1'b1;
        end else if (n1h && is_letter(n1)) begin
          res.ok   = 1'b1;
          res.next = pps_pkg::MODE_LETTER;
          done     = 1'b1;
        end else if (c == pps_pkg::CH_SPACE && n1h && is_punct(n1)) begin
          res.ok   = 1'b1;
          res.next = pps_pkg::MODE_PUNCT;
          done     = 1'b1;
        end
      end
      if (!done && is_digit(c)) begin
        res.ok   = 1'b1;
        res.pend = 1'b1;
        res.next = pps_pkg::MODE_START;
        done     = 1'b1;
      end
      if (!done) begin
        m = is_letter(c) ? pps_pkg::MODE_LETTER :
            is_punct(c)  ? pps_pkg::MODE_PUNCT  :
            is_break(c)  ? pps_pkg::MODE_BREAK  : pps_pkg::MODE_SPACE;
      end
    end
    // Continue an open piece
    if (!done) begin
      if (m == pps_pkg::MODE_TAIL2) begin
        res.ok   = 1'b1;
        res.next = pps_pkg::MODE_TAIL1;
      end else if (m == pps_pkg::MODE_TAIL1) begin
        res.ok   = 1'b1;
        res.pend = 1'b1;
        res.next = pps_pkg::MODE_START;
      end else if (!n1u) begin
        case (m)
          pps_pkg::MODE_LETTER: begin
            if (n1h && is_letter(n1)) nx = pps_pkg::MODE_LETTER;
          end
          pps_pkg::MODE_PUNCT: begin
            if (n1h && is_punct(n1)) begin
              nx = pps_pkg::MODE_PUNCT;
            end else if (n1h && is_break(n1)) begin
              nx = pps_pkg::MODE_BREAK;
            end
          end
          pps_pkg::MODE_BREAK: begin
            if (n1h && is_break(n1)) nx = pps_pkg::MODE_BREAK;
          end
          default: begin
            // Whitespace run: a lone space before punctuation goes to the next piece
            if (n1h && is_space(n1)) begin
              if (is_break(n1)) begin
                nx = pps_pkg::MODE_BREAK;
              end else if (n1 == pps_pkg::CH_SPACE) begin
                if (n2u) begin
                  wait_n2 = 1'b1;
                end else if (!(n2h && is_punct(n2))) begin
                  nx = pps_pkg::MODE_SPACE;
                end
              end else begin
                nx = pps_pkg::MODE_SPACE;
              end
            end
          end
        endcase
        res.ok   = !wait_n2;
        res.next = nx;
        res.pend = (nx == pps_pkg::MODE_START);
      end
    end
    return res;
  endfunction

  // Chain up to three decisions over the held bytes plus the new one
  always_comb begin
    logic [7:0] q0, q1, q2;
    logic [1:0] n;
    logic [2:0] mode;
    logic       go;
    logic       fin;
    pps_dec_t   d;
    fin  = item.text_end;
    q0   = item.byte_in;
    q1   = item.byte_in;
    q2   = item.byte_in;
    case (hold.held_cnt)
      2'd0: begin
        q0 = item.byte_in;
      end
      2'd1: begin
        q0 = hold.b0;
      end
      default: begin
        q0 = hold.b0;
        q1 = hold.b1;
      end
    endcase
    n    = (hold.held_cnt > 2'd2) ? 2'd3 : hold.held_cnt + 2'd1;
    mode = hold.mode;
    go   = 1'b1;
    grp  = '0;
    d    = '0;
    for (int k = 0; k < pps_pkg::MAX_RES; k++) begin
      if (go && n != 2'd0) begin
        d = decide(q0, q1, q2, n, fin, mode);
        if (d.ok) begin
          grp.res[k].byte_out  = q0;
          grp.res[k].piece_end = d.pend | (fin && n == 2'd1);
          mode    = d.next;
          q0      = q1;
          q1      = q2;
          n       = n - 2'd1;
          grp.cnt = grp.cnt + 2'd1;
        end else begin
          go = 1'b0;
        end
      end
    end
    // Flag the last result of this item
    for (int k = 0; k < pps_pkg::MAX_RES; k++) begin
      grp.res[k].run_last = (grp.cnt != 2'd0) && (2'(k) == grp.cnt - 2'd1);
    end
    hold_nxt.held_cnt = fin ? 2'd0 : n;
    hold_nxt.mode     = fin ? pps_pkg::MODE_START : mode;
    hold_nxt.b0       = q0;
    hold_nxt.b1       = q1;
  end

endmodule

`default_nettype wire

// ===== rtl/core/pps_outq.sv =====
// Result queue: takes up to three results per cycle, hands out one per cycle
// through an output register while out_stall is low. Depends on pps_pkg.
`default_nettype none

module pps_outq #(
  parameter int unsigned DEPTH = pps_pkg::OUTQ_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  pps_pkg::pps_grp_t   grp,
  output logic                room,
  output logic                out_vld,
  input  logic                out_stall,
  output pps_pkg::pps_out_t   out_data
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  pps_pkg::pps_out_t mem [DEPTH];
  logic [AW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [CW-1:0]     push_n;
  logic              load;
  logic              out_vld_r;
  pps_pkg::pps_out_t out_data_r;
  logic [AW-1:0]     widx [pps_pkg::MAX_RES];

  // Refill the output register when it is empty or being taken
  assign load     = (count_r != '0) && (!out_vld_r || !out_stall);
  assign out_vld  = out_vld_r;
  assign out_data = out_data_r;
  assign room     = count_r <= CW'(DEPTH - pps_pkg::MAX_RES);
  assign push_n   = push ? CW'(grp.cnt) : '0;

  // Advance pointers and fill level
  always_comb begin
    for (int k = 0; k < pps_pkg::MAX_RES; k++) begin
      widx[k] = wr_ptr_r + AW'(k);
    end
    wr_ptr_nxt = wr_ptr_r + AW'(push_n);
    rd_ptr_nxt = rd_ptr_r + AW'(load);
    count_nxt  = count_r + push_n - CW'(load);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r  <= '0;
      rd_ptr_r  <= '0;
      count_r   <= '0;
      out_vld_r <= 1'b0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
      if (!out_vld_r || !out_stall) begin
        out_vld_r <= count_r != '0;
      end
    end
  end

  // Write the new results in order, read the oldest into the output register
  always_ff @(posedge clk) begin
    for (int k = 0; k < pps_pkg::MAX_RES; k++) begin
      if (push && 2'(k) < grp.cnt) begin
        mem[widx[k]] <= grp.res[k];
      end
    end
    if (load) begin
      out_data_r <= mem[rd_ptr_r];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/pretoken_piece_splitter.sv =====
// Pretoken piece splitter top level: input register, piece decision, result queue.
// Depends on pps_pkg, pps_step and pps_outq.
//
//   port group   dir   payload              role
//   in_*         in    pps_in_t  (9 bits)   raw text bytes, text_end on the last
//   out_*        out   pps_out_t (10 bits)  decided bytes with piece_end, run_last
//
// One input item per cycle is taken while in_stall is low; it is held in the input
// register, where it is decided and up to three results enter the result queue.
// The first result of an item passes the queue into the output register and is
// offered on out_. Results leave one per cycle while out_stall is low; the input
// stalls while the queue lacks room for three results. Reset is synchronous,
// active low.
`default_nettype none

module pretoken_piece_splitter #(
  parameter int unsigned OUTQ_DEPTH = pps_pkg::OUTQ_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_vld,
  output logic              in_stall,
  input  pps_pkg::pps_in_t  in_data,
  output logic              out_vld,
  input  logic              out_stall,
  output pps_pkg::pps_out_t out_data
);

  logic               in_vld_r;
  pps_pkg::pps_in_t   in_item_r;
  logic [1:0]         held_cnt_r;
  logic [2:0]         mode_r;
  logic [7:0]         b0_r, b1_r;
  pps_pkg::pps_hold_t hold, hold_nxt;
  pps_pkg::pps_grp_t  grp;
  logic               room;
  logic               consume;

  assign consume  = in_vld_r && room;
  assign in_stall = in_vld_r && !room;

  // Hold the input item until the queue has room
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_vld) begin
      in_item_r <= in_data;
    end
  end

  // Update held bytes and piece mode when an item is decided
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_cnt_r <= 2'd0;
      mode_r     <= pps_pkg::MODE_START;
    end else if (consume) begin
      held_cnt_r <= hold_nxt.held_cnt;
      mode_r     <= hold_nxt.mode;
    end
  end

  always_ff @(posedge clk) begin
    if (consume) begin
      b0_r <= hold_nxt.b0;
      b1_r <= hold_nxt.b1;
    end
  end

  assign hold.held_cnt = held_cnt_r;
  assign hold.mode     = mode_r;
  assign hold.b0       = b0_r;
  assign hold.b1       = b1_r;

  pps_step u_step (
    .hold     (hold),
    .item     (in_item_r),
    .grp      (grp),
    .hold_nxt (hold_nxt)
  );

  pps_outq #(
    .DEPTH (OUTQ_DEPTH)
  ) u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (consume),
    .grp       (grp),
    .room      (room),
    .out_vld   (out_vld),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ===== rtl/core/pps_checker.sv =====
// Port checker for the pretoken piece splitter, bound to its top level.
// Depends on pps_pkg.
`default_nettype none

module pps_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_vld,
  input logic              in_stall,
  input pps_pkg::pps_in_t  in_data,
  input logic              out_vld,
  input logic              out_stall,
  input pps_pkg::pps_out_t out_data
);

  // Leave reset with no pending item and an empty queue
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_vld && !in_stall)
    else $error("pps: not empty after reset");

  // A stalled input item holds
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld && in_stall |=> in_vld && $stable(in_data))
    else $error("pps: stalled input changed");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld && out_stall |=> out_vld && $stable(out_data))
    else $error("pps: stalled result changed");

  // Results of one item leave back to back
  a_run_follow: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld && !out_stall && !out_data.run_last |=> out_vld)
    else $error("pps: result of an item missing");

  // A digit is always a piece of its own
  a_digit_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld && out_data.byte_out >= pps_pkg::CH_0 && out_data.byte_out <= pps_pkg::CH_9
      |-> out_data.piece_end)
    else $error("pps: digit without piece end");

endmodule

bind pretoken_piece_splitter pps_checker u_pps_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_vld    (in_vld),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_vld   (out_vld),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
